/* rtl/core/rope_pkg.sv */
package rope_pkg;

    // Fixed field widths
    localparam int ROW_W     = 9;
    localparam int PAIR_IN_W = 6;
    localparam int COEF_W    = 16;
    localparam int IDX_W     = 8;
    localparam int HR_W      = 7;
    localparam int HL_W      = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 9;

    // Q1.14 coefficients: round half up, then drop the fraction
    localparam int FRAC_W     = 14;
    localparam int ROUND_BIAS = 8192;

    // Row reduction by reciprocal multiply; exact for every 9-bit row
    localparam int RECIP_SH = 18;

    localparam int QUEUE_DEPTH = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_INTERLEAVED = 2'd0;
    localparam cfg_idx_t REG_HALF_ROTARY = 2'd1;
    localparam cfg_idx_t REG_HEAD_LENGTH = 2'd2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    localparam logic [HR_W-1:0] HALF_ROTARY_RESET = 7'd32;
    localparam logic [HL_W-1:0] HEAD_LENGTH_RESET = 9'd64;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_BUFFER,
        OP_PASS,
        OP_PAIR
    } op_kind_t;

    typedef struct packed {
        op_kind_t kind;
        logic     done;
    } op_ctl_t;

endpackage

/* rtl/core/rotary_position_embedding.sv */
// Rotary position embedding. Takes cosine/sine table loads and head-vector elements on one
// input channel and returns at most one result per cycle. A rotated pair leaves as two
// consecutive results once its second element arrives; pass-through elements leave as one.
// The first result passes through five registers: front register (loaded at the accepting
// edge), issue queue, table/pair-buffer read, multiply, round/saturate. Throughput is set
// by the single output register: a rotated pair holds it for both of its results. In
// interleaved mode the buffered element of each pair slips past meanwhile, so the input
// keeps one transaction per cycle while out_ready stays high. In split mode the first-half
// elements are only buffered and each second-half element then waits for the output
// register to finish the previous pair. Tables and the pair buffer come up undefined;
// entries must be loaded before they are used, no clearing pass. A write to any of the
// three configuration registers restarts the head vector.
module rotary_position_embedding #(
    parameter int MAX_POSITIONS   = 512,
    parameter int MAX_HALF_ROTARY = 64,
    parameter int MAX_HEAD_LENGTH = 256,
    parameter int DATA_WIDTH      = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  rope_pkg::cfg_idx_t                cfg_index,
    input  logic [rope_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [rope_pkg::ROW_W-1:0]        table_row,
    input  logic [rope_pkg::PAIR_IN_W-1:0]    pair_index,
    input  logic signed [rope_pkg::COEF_W-1:0] cos_value,
    input  logic signed [rope_pkg::COEF_W-1:0] sin_value,
    input  logic signed [DATA_WIDTH-1:0]      element_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rope_pkg::IDX_W-1:0]        element_index,
    output logic signed [DATA_WIDTH-1:0]      result_value,
    output logic                              last_of_run,
    output logic                              head_done
);
    import rope_pkg::*;

    localparam int PA_W = (MAX_HALF_ROTARY > 1) ? $clog2(MAX_HALF_ROTARY) : 1;
    localparam int Q_W  = $bits(op_ctl_t) + 2 * ROW_W + PA_W + 2 * COEF_W
                          + DATA_WIDTH + 2 * IDX_W;

    logic                         fe_valid, fe_ready;
    op_ctl_t                      fe_ctl;
    logic [ROW_W-1:0]             fe_row, fe_rowq;
    logic [PA_W-1:0]              fe_pair;
    logic signed [COEF_W-1:0]     fe_cos, fe_sin;
    logic signed [DATA_WIDTH-1:0] fe_x;
    logic [IDX_W-1:0]             fe_idx0, fe_idx1;

    logic                         q_valid, q_ready;
    logic [Q_W-1:0]               q_in, q_out;
    op_ctl_t                      q_ctl;
    logic [ROW_W-1:0]             q_row, q_rowq;
    logic [PA_W-1:0]              q_pair;
    logic signed [COEF_W-1:0]     q_cos, q_sin;
    logic signed [DATA_WIDTH-1:0] q_x;
    logic [IDX_W-1:0]             q_idx0, q_idx1;

    rope_front #(
        .MAX_POSITIONS   (MAX_POSITIONS),
        .MAX_HALF_ROTARY (MAX_HALF_ROTARY),
        .MAX_HEAD_LENGTH (MAX_HEAD_LENGTH),
        .DATA_WIDTH      (DATA_WIDTH),
        .PA_W            (PA_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .table_row     (table_row),
        .pair_index    (pair_index),
        .cos_value     (cos_value),
        .sin_value     (sin_value),
        .element_value (element_value),
        .f_valid       (fe_valid),
        .f_ready       (fe_ready),
        .f_ctl         (fe_ctl),
        .f_row         (fe_row),
        .f_rowq        (fe_rowq),
        .f_pair        (fe_pair),
        .f_cos         (fe_cos),
        .f_sin         (fe_sin),
        .f_x           (fe_x),
        .f_idx0        (fe_idx0),
        .f_idx1        (fe_idx1)
    );

    assign q_in = {fe_ctl, fe_row, fe_rowq, fe_pair, fe_cos, fe_sin, fe_x, fe_idx0, fe_idx1};

    rope_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_data  (q_in),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_out)
    );

    assign {q_ctl, q_row, q_rowq, q_pair, q_cos, q_sin, q_x, q_idx0, q_idx1} = q_out;

    rope_back #(
        .MAX_POSITIONS   (MAX_POSITIONS),
        .MAX_HALF_ROTARY (MAX_HALF_ROTARY),
        .DATA_WIDTH      (DATA_WIDTH),
        .PA_W            (PA_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_ctl         (q_ctl),
        .q_row         (q_row),
        .q_rowq        (q_rowq),
        .q_pair        (q_pair),
        .q_cos         (q_cos),
        .q_sin         (q_sin),
        .q_x           (q_x),
        .q_idx0        (q_idx0),
        .q_idx1        (q_idx1),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .element_index (element_index),
        .result_value  (result_value),
        .last_of_run   (last_of_run),
        .head_done     (head_done)
    );

    // first beat of a pair is always followed by its closing beat, same head flag
    a_pair_second_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run
        |=> out_valid && last_of_run && head_done == $past(head_done))
        else $error("pair transaction not closed by its second beat");

    // table loads never wait on the back-end pipeline
    a_load_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_ctl.kind == OP_LOAD |-> q_ready)
        else $error("table load stalled at back end");

    // a table load never carries the head-end flag
    a_front_drop: assert property (@(posedge clk) disable iff (!rst_n)
        fe_valid && (fe_ctl.kind == OP_LOAD || fe_ctl.kind == OP_BUFFER) |-> !fe_ctl.done
        || fe_ctl.kind == OP_BUFFER)
        else $error("load transaction flagged as head end");

endmodule

/* rtl/core/rope_front.sv */
module rope_front #(
    parameter int MAX_POSITIONS   = 512,
    parameter int MAX_HALF_ROTARY = 64,
    parameter int MAX_HEAD_LENGTH = 256,
    parameter int DATA_WIDTH      = 16,
    parameter int PA_W            = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  rope_pkg::cfg_idx_t                cfg_index,
    input  logic [rope_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [rope_pkg::ROW_W-1:0]        table_row,
    input  logic [rope_pkg::PAIR_IN_W-1:0]    pair_index,
    input  logic signed [rope_pkg::COEF_W-1:0] cos_value,
    input  logic signed [rope_pkg::COEF_W-1:0] sin_value,
    input  logic signed [DATA_WIDTH-1:0]      element_value,
    output logic                              f_valid,
    input  logic                              f_ready,
    output rope_pkg::op_ctl_t                 f_ctl,
    output logic [rope_pkg::ROW_W-1:0]        f_row,
    output logic [rope_pkg::ROW_W-1:0]        f_rowq,
    output logic [PA_W-1:0]                   f_pair,
    output logic signed [rope_pkg::COEF_W-1:0] f_cos,
    output logic signed [rope_pkg::COEF_W-1:0] f_sin,
    output logic signed [DATA_WIDTH-1:0]      f_x,
    output logic [rope_pkg::IDX_W-1:0]        f_idx0,
    output logic [rope_pkg::IDX_W-1:0]        f_idx1
);
    import rope_pkg::*;

    localparam int MHL_W  = $clog2(MAX_HEAD_LENGTH + 1);
    localparam int W      = (MHL_W > HL_W) ? MHL_W : HL_W;
    localparam int CNT_W  = $clog2(MAX_HEAD_LENGTH);
    localparam int PROD_W = ROW_W + RECIP_SH + 1;
    localparam logic [PROD_W-1:0] RECIP = PROD_W'((2 ** RECIP_SH) / MAX_POSITIONS + 1);

    logic                 interleaved_reg, interleaved_next;
    logic [HR_W-1:0]      half_rotary_reg, half_rotary_next;
    logic [HL_W-1:0]      head_length_reg, head_length_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic                 f_valid_reg, f_valid_next;
    op_ctl_t              f_ctl_reg;
    logic [ROW_W-1:0]     f_row_reg, f_rowq_reg;
    logic [PA_W-1:0]      f_pair_reg;
    logic signed [COEF_W-1:0] f_cos_reg, f_sin_reg;
    logic signed [DATA_WIDTH-1:0] f_x_reg;
    logic [IDX_W-1:0]     f_idx0_reg, f_idx1_reg;

    logic [W-1:0]         hl_raw, hl_eff, hr_raw, hr_clamp, hr_eff, two_hr;
    logic [W-1:0]         cur, cur_inc, pair_w;
    logic                 accept, keep, done;
    logic [PROD_W-1:0]    row_prod;
    op_ctl_t              ctl_c;
    logic [PA_W-1:0]      pair_c;
    logic [IDX_W-1:0]     idx0_c;

    // Effective geometry after clamping
    always_comb
    begin
        hl_raw   = W'(head_length_reg);
        hl_eff   = (hl_raw < W'(2)) ? W'(2) :
                   (hl_raw > W'(MAX_HEAD_LENGTH)) ? W'(MAX_HEAD_LENGTH) : hl_raw;
        hr_raw   = W'(half_rotary_reg);
        hr_clamp = (hr_raw < W'(1)) ? W'(1) :
                   (hr_raw > W'(MAX_HALF_ROTARY)) ? W'(MAX_HALF_ROTARY) : hr_raw;
        hr_eff   = ((hr_clamp << 1) > hl_eff) ? (hl_eff >> 1) : hr_clamp;
        two_hr   = hr_eff << 1;
    end

    assign cur     = (W'(cnt_reg) >= hl_eff) ? '0 : W'(cnt_reg);
    assign cur_inc = cur + W'(1);
    assign done    = (cur_inc >= hl_eff);

    assign row_prod = PROD_W'(table_row) * RECIP;

    assign in_ready = !f_valid_reg || f_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        ctl_c.kind = OP_PASS;
        ctl_c.done = done;
        pair_c     = '0;
        idx0_c     = '0;
        keep       = 1'b1;
        pair_w     = '0;
        if (req_type == REQ_LOAD)
        begin
            ctl_c.kind = OP_LOAD;
            ctl_c.done = 1'b0;
            pair_c     = PA_W'(pair_index);
            keep       = (W'(pair_index) < W'(MAX_HALF_ROTARY));
        end
        else if (cur >= two_hr)
        begin
            ctl_c.kind = OP_PASS;
        end
        else if (interleaved_reg)
        begin
            pair_w     = cur >> 1;
            pair_c     = PA_W'(pair_w);
            ctl_c.kind = cur[0] ? OP_PAIR : OP_BUFFER;
            idx0_c     = IDX_W'(cur - W'(1));
        end
        else if (cur < hr_eff)
        begin
            ctl_c.kind = OP_BUFFER;
            pair_c     = PA_W'(cur);
        end
        else
        begin
            pair_w     = cur - hr_eff;
            pair_c     = PA_W'(pair_w);
            ctl_c.kind = OP_PAIR;
            idx0_c     = IDX_W'(pair_w);
        end
    end

    always_comb
    begin
        interleaved_next = interleaved_reg;
        half_rotary_next = half_rotary_reg;
        head_length_next = head_length_reg;
        cnt_next         = cnt_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INTERLEAVED:
                begin
                    interleaved_next = cfg_data[0];
                    cnt_next         = '0;
                end
                REG_HALF_ROTARY:
                begin
                    half_rotary_next = cfg_data[HR_W-1:0];
                    cnt_next         = '0;
                end
                REG_HEAD_LENGTH:
                begin
                    head_length_next = cfg_data[HL_W-1:0];
                    cnt_next         = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept && req_type == REQ_DATA)
        begin
            cnt_next = done ? '0 : cur_inc[CNT_W-1:0];
        end
    end

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
            f_valid_next = keep;
        else if (f_ready)
            f_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interleaved_reg <= 1'b0;
            half_rotary_reg <= HALF_ROTARY_RESET;
            head_length_reg <= HEAD_LENGTH_RESET;
            cnt_reg         <= '0;
            f_valid_reg     <= 1'b0;
        end
        else
        begin
            interleaved_reg <= interleaved_next;
            half_rotary_reg <= half_rotary_next;
            head_length_reg <= head_length_next;
            cnt_reg         <= cnt_next;
            f_valid_reg     <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_ctl_reg  <= ctl_c;
            f_row_reg  <= table_row;
            f_rowq_reg <= row_prod[RECIP_SH +: ROW_W];
            f_pair_reg <= pair_c;
            f_cos_reg  <= cos_value;
            f_sin_reg  <= sin_value;
            f_x_reg    <= element_value;
            f_idx0_reg <= idx0_c;
            f_idx1_reg <= IDX_W'(cur);
        end
    end

    assign f_valid = f_valid_reg;
    assign f_ctl   = f_ctl_reg;
    assign f_row   = f_row_reg;
    assign f_rowq  = f_rowq_reg;
    assign f_pair  = f_pair_reg;
    assign f_cos   = f_cos_reg;
    assign f_sin   = f_sin_reg;
    assign f_x     = f_x_reg;
    assign f_idx0  = f_idx0_reg;
    assign f_idx1  = f_idx1_reg;

endmodule

/* rtl/core/rope_queue.sv */
module rope_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* rtl/core/rope_back.sv */
module rope_back #(
    parameter int MAX_POSITIONS   = 512,
    parameter int MAX_HALF_ROTARY = 64,
    parameter int DATA_WIDTH      = 16,
    parameter int PA_W            = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  rope_pkg::op_ctl_t                 q_ctl,
    input  logic [rope_pkg::ROW_W-1:0]        q_row,
    input  logic [rope_pkg::ROW_W-1:0]        q_rowq,
    input  logic [PA_W-1:0]                   q_pair,
    input  logic signed [rope_pkg::COEF_W-1:0] q_cos,
    input  logic signed [rope_pkg::COEF_W-1:0] q_sin,
    input  logic signed [DATA_WIDTH-1:0]      q_x,
    input  logic [rope_pkg::IDX_W-1:0]        q_idx0,
    input  logic [rope_pkg::IDX_W-1:0]        q_idx1,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rope_pkg::IDX_W-1:0]        element_index,
    output logic signed [DATA_WIDTH-1:0]      result_value,
    output logic                              last_of_run,
    output logic                              head_done
);
    import rope_pkg::*;

    localparam int PR_W = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int MW   = DATA_WIDTH + COEF_W;
    localparam int AW   = DATA_WIDTH + COEF_W + 2;
    localparam logic signed [AW-1:0] SAT_HI = (AW'(1) << (DATA_WIDTH - 1)) - AW'(1);
    localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

    function automatic logic signed [DATA_WIDTH-1:0] round_sat(
        input logic signed [AW-1:0] a
    );
        logic signed [AW-1:0] t;
        logic signed [AW-1:0] q;
        t = a + AW'(ROUND_BIAS);
        q = t >>> FRAC_W;
        if (q > SAT_HI)
            q = SAT_HI;
        else if (q < SAT_LO)
            q = SAT_LO;
        return q[DATA_WIDTH-1:0];
    endfunction

    logic signed [COEF_W-1:0]     cos_mem [MAX_POSITIONS][MAX_HALF_ROTARY];
    logic signed [COEF_W-1:0]     sin_mem [MAX_POSITIONS][MAX_HALF_ROTARY];
    logic signed [DATA_WIDTH-1:0] pbuf_mem [MAX_HALF_ROTARY];

    logic [ROW_W-1:0] row_sub, row_mod;
    logic [PR_W-1:0]  row_idx;
    logic             is_res, pop;

    // stage 1: memory read data
    logic                         s1_valid_reg, s1_valid_next;
    op_ctl_t                      s1_ctl_reg;
    logic signed [COEF_W-1:0]     s1_c_reg, s1_s_reg;
    logic signed [DATA_WIDTH-1:0] s1_pb_reg, s1_x_reg;
    logic [IDX_W-1:0]             s1_idx0_reg, s1_idx1_reg;
    logic                         s1_adv, s1_free;

    // stage 2: rotated sums
    logic                         s2_valid_reg, s2_valid_next;
    op_ctl_t                      s2_ctl_reg;
    logic signed [AW-1:0]         s2_acc0_reg, s2_acc1_reg;
    logic signed [DATA_WIDTH-1:0] s2_x_reg;
    logic [IDX_W-1:0]             s2_idx0_reg, s2_idx1_reg;
    logic                         s2_adv, s2_free;

    // output stage: one or two beats
    logic                         o_valid_reg, o_valid_next;
    logic                         o_second_reg, o_second_next;
    op_ctl_t                      o_ctl_reg;
    logic signed [DATA_WIDTH-1:0] o_y0_reg, o_y1_reg;
    logic [IDX_W-1:0]             o_idx0_reg, o_idx1_reg;
    logic                         o_single, o_free;

    logic signed [MW-1:0] m_pc, m_xs, m_ps, m_xc;

    assign row_sub = ROW_W'(32'(q_rowq) * MAX_POSITIONS);
    assign row_mod = q_row - row_sub;
    assign row_idx = PR_W'(row_mod);

    assign is_res  = (q_ctl.kind == OP_PASS) || (q_ctl.kind == OP_PAIR);
    assign q_ready = !is_res || s1_free;
    assign pop     = q_valid && q_ready;

    assign o_single = (o_ctl_reg.kind == OP_PASS) || o_second_reg;
    assign o_free   = !o_valid_reg || (out_ready && o_single);
    assign s2_adv   = s2_valid_reg && o_free;
    assign s2_free  = !s2_valid_reg || s2_adv;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_adv;

    // table and pair buffer: writes and reads at the same point keep program order
    always_ff @(posedge clk)
    begin
        if (pop && q_ctl.kind == OP_LOAD)
        begin
            cos_mem[row_idx][q_pair] <= q_cos;
            sin_mem[row_idx][q_pair] <= q_sin;
        end
        if (pop && q_ctl.kind == OP_BUFFER)
            pbuf_mem[q_pair] <= q_x;
        if (pop && is_res)
        begin
            s1_c_reg    <= cos_mem[row_idx][q_pair];
            s1_s_reg    <= sin_mem[row_idx][q_pair];
            s1_pb_reg   <= pbuf_mem[q_pair];
            s1_ctl_reg  <= q_ctl;
            s1_x_reg    <= q_x;
            s1_idx0_reg <= q_idx0;
            s1_idx1_reg <= q_idx1;
        end
    end

    assign m_pc = s1_pb_reg * s1_c_reg;
    assign m_xs = s1_x_reg * s1_s_reg;
    assign m_ps = s1_pb_reg * s1_s_reg;
    assign m_xc = s1_x_reg * s1_c_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_acc0_reg <= AW'(m_pc) - AW'(m_xs);
            s2_acc1_reg <= AW'(m_ps) + AW'(m_xc);
            s2_ctl_reg  <= s1_ctl_reg;
            s2_x_reg    <= s1_x_reg;
            s2_idx0_reg <= s1_idx0_reg;
            s2_idx1_reg <= s1_idx1_reg;
        end
        if (s2_adv)
        begin
            o_y0_reg   <= round_sat(s2_acc0_reg);
            o_y1_reg   <= (s2_ctl_reg.kind == OP_PASS) ? s2_x_reg : round_sat(s2_acc1_reg);
            o_ctl_reg  <= s2_ctl_reg;
            o_idx0_reg <= s2_idx0_reg;
            o_idx1_reg <= s2_idx1_reg;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pop && is_res)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        s2_valid_next = s2_valid_reg;
        if (s1_adv)
            s2_valid_next = 1'b1;
        else if (s2_adv)
            s2_valid_next = 1'b0;

        o_valid_next  = o_valid_reg;
        o_second_next = o_second_reg;
        if (s2_adv)
        begin
            o_valid_next  = 1'b1;
            o_second_next = 1'b0;
        end
        else if (o_valid_reg && out_ready)
        begin
            if (o_single)
                o_valid_next = 1'b0;
            else
                o_second_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
            o_second_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            o_valid_reg  <= o_valid_next;
            o_second_reg <= o_second_next;
        end
    end

    assign out_valid     = o_valid_reg;
    assign element_index = o_single ? o_idx1_reg : o_idx0_reg;
    assign result_value  = o_single ? o_y1_reg : o_y0_reg;
    assign last_of_run   = o_single;
    assign head_done     = o_ctl_reg.done;

endmodule
